// ===== sv/chfd_pkg.sv =====
`default_nettype none

package chfd_pkg;

  localparam int unsigned SSID_MAX        = 32;
  localparam int unsigned PASSWORD_MAX    = 64;
  localparam int unsigned KEY_MAX         = 32;
  localparam int unsigned RESERVED_FIELDS = 6;

  localparam int unsigned FieldW = 4;
  localparam int unsigned IndexW = 7;

  localparam logic [FieldW-1:0] FldSecurity = 4'd0;
  localparam logic [FieldW-1:0] FldSsid     = 4'd1;
  localparam logic [FieldW-1:0] FldPassword = 4'd2;
  localparam logic [FieldW-1:0] FldKey      = 4'd3;
  localparam logic [FieldW-1:0] FldCrc      = FieldW'(4 + RESERVED_FIELDS);

  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] Ch0     = 8'h30;
  localparam logic [7:0] Ch9     = 8'h39;
  localparam logic [7:0] ChA     = 8'h41;
  localparam logic [7:0] ChF     = 8'h46;

  localparam logic [3:0] NibSec0 = 4'd0;
  localparam logic [3:0] NibSec2 = 4'd2;
  localparam logic [3:0] NibSec3 = 4'd3;
  localparam logic [3:0] NibSec4 = 4'd4;
  localparam logic [3:0] NibSec8 = 4'd8;

  typedef enum logic [2:0] {
    StOk          = 3'd0,
    StBadLetter   = 3'd1,
    StBadSecurity = 3'd2,
    StExtraCrc    = 3'd3,
    StFieldFull   = 3'd4
  } status_e;

  function automatic logic [IndexW-1:0] field_limit(input logic [FieldW-1:0] fld);
    logic [IndexW-1:0] lim;
    if (fld == FldSsid) begin
      lim = IndexW'(SSID_MAX);
    end else if (fld == FldPassword) begin
      lim = IndexW'(PASSWORD_MAX);
    end else begin
      lim = IndexW'(KEY_MAX);
    end
    return lim;
  endfunction

endpackage

`default_nettype wire

// ===== sv/credential_hex_field_deframer_top.sv =====
// Output: each accepted letter's result is registered directly in the output register.
// Throughput: one letter per cycle; a new letter is taken whenever the output
// register is empty or its result is transferred in the same cycle.
// Reset: asynchronous, active low; returns to the security field, index zero,
// high nibble expected, output register empty.
`default_nettype none

module credential_hex_field_deframer_top
  import chfd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [7:0]        code_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [2:0]             status_o,
  output logic [FieldW-1:0]      field_id_o,
  output logic                   byte_valid_o,
  output logic [7:0]             byte_value_o,
  output logic [IndexW-1:0]      byte_index_o,
  output logic                   terminate_valid_o,
  output logic [1:0]             terminated_field_o,
  output logic                   security_valid_o,
  output logic [3:0]             security_value_o
);

  logic [FieldW-1:0] field_q, field_d;
  logic [IndexW-1:0] fill_q, fill_d;
  logic [7:0]        part_q, part_d;
  logic              hi_q, hi_d;

  logic              out_valid_q;
  status_e           status_q, status_d;
  logic [FieldW-1:0] fid_q;
  logic              bv_q, bv_d;
  logic [7:0]        bval_q, bval_d;
  logic [IndexW-1:0] bidx_q, bidx_d;
  logic              tv_q, tv_d;
  logic [1:0]        tf_q, tf_d;
  logic              sv_q, sv_d;
  logic [3:0]        sval_q, sval_d;

  logic       in_xfer;
  logic       is_sep, is_dig, is_uc, is_hex;
  logic [3:0] nib, sec_nib;
  logic [7:0] byte_new;
  logic       done;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign is_sep  = (code_i == ChSlash);
  assign is_dig  = (code_i >= Ch0) && (code_i <= Ch9);
  assign is_uc   = (code_i >= ChA) && (code_i <= ChF);
  assign is_hex  = is_dig || is_uc;
  assign nib     = is_dig ? code_i[3:0] : (code_i[3:0] + 4'd9);
  assign sec_nib = (nib == NibSec3) ? NibSec2 : nib;

  always_comb begin
    field_d  = field_q;
    fill_d   = fill_q;
    part_d   = part_q;
    hi_d     = hi_q;
    status_d = StOk;
    bv_d     = 1'b0;
    bval_d   = 8'h00;
    bidx_d   = '0;
    tv_d     = 1'b0;
    tf_d     = 2'd0;
    sv_d     = 1'b0;
    sval_d   = 4'd0;
    byte_new = part_q;
    done     = 1'b0;
    if (is_sep) begin
      if (field_q >= FldSsid && field_q <= FldKey) begin
        tv_d   = 1'b1;
        tf_d   = field_q[1:0];
        bidx_d = fill_q;
      end
      if (field_q != FldCrc) begin
        field_d = field_q + FieldW'(1);
      end
      hi_d   = 1'b1;
      fill_d = '0;
    end else if (!is_hex) begin
      status_d = StBadLetter;
    end else if (field_q == FldSecurity) begin
      if (sec_nib == NibSec0 || sec_nib == NibSec2 || sec_nib == NibSec4 ||
          sec_nib == NibSec8) begin
        sv_d   = 1'b1;
        sval_d = sec_nib;
      end else begin
        status_d = StBadSecurity;
      end
    end else begin
      if (field_q == FldKey) begin
        byte_new = code_i;
        done     = 1'b1;
      end else if (hi_q) begin
        byte_new = {nib, 4'h0};
        hi_d     = 1'b0;
      end else begin
        byte_new = part_q + {4'h0, nib};
        hi_d     = 1'b1;
        done     = 1'b1;
      end
      part_d = byte_new;
      if (done) begin
        if (field_q == FldCrc) begin
          if (fill_q != '0) begin
            status_d = StExtraCrc;
          end else begin
            bv_d   = 1'b1;
            bval_d = byte_new;
            fill_d = IndexW'(1);
          end
        end else if (fill_q >= field_limit(field_q)) begin
          status_d = StFieldFull;
        end else begin
          bv_d   = 1'b1;
          bval_d = byte_new;
          bidx_d = fill_q;
          fill_d = fill_q + IndexW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_q     <= FldSecurity;
      fill_q      <= '0;
      part_q      <= 8'h00;
      hi_q        <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        field_q     <= field_d;
        fill_q      <= fill_d;
        part_q      <= part_d;
        hi_q        <= hi_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      status_q <= status_d;
      fid_q    <= field_d;
      bv_q     <= bv_d;
      bval_q   <= bval_d;
      bidx_q   <= bidx_d;
      tv_q     <= tv_d;
      tf_q     <= tf_d;
      sv_q     <= sv_d;
      sval_q   <= sval_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign field_id_o         = fid_q;
  assign byte_valid_o       = bv_q;
  assign byte_value_o       = bval_q;
  assign byte_index_o       = bidx_q;
  assign terminate_valid_o  = tv_q;
  assign terminated_field_o = tf_q;
  assign security_valid_o   = sv_q;
  assign security_value_o   = sval_q;

`ifndef SYNTHESIS
  a_field_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    field_q <= FldCrc)
    else $error("field number beyond crc field");

  a_single_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(byte_valid_o && terminate_valid_o) &&
                    !(byte_valid_o && security_valid_o) &&
                    !(terminate_valid_o && security_valid_o))
    else $error("more than one event in one result");

  a_status_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != StOk) |-> !byte_valid_o && !security_valid_o)
    else $error("byte or security reported with error status");

  a_term_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && terminate_valid_o |-> terminated_field_o != 2'd0 &&
      field_id_o == {2'b00, terminated_field_o} + FieldW'(1))
    else $error("terminator without string field");

  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && !is_sep |=> (fill_q == $past(fill_q)) ||
                           (fill_q == $past(fill_q) + IndexW'(1)))
    else $error("fill index jumped on data letter");
`endif

endmodule

`default_nettype wire
